FILE: rtl/tbp_pkg.sv
package tbp_pkg;

  localparam int CTR_W = 2;

  localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

  // Reset contents of the counter tables.
  localparam logic [CTR_W-1:0] GSHARE_INIT  = 2'd0;
  localparam logic [CTR_W-1:0] CHOOSER_INIT = 2'd2;
  localparam logic [CTR_W-1:0] LCTR_INIT    = 2'd0;

  // Request kinds carried on the input tuser bit.
  localparam logic KIND_TRAIN = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LH,
    S_EVAL
  } state_t;

  // One word of the gshare-indexed memory: chooser and gshare counter side by side.
  typedef struct packed {
    logic [CTR_W-1:0] chooser;
    logic [CTR_W-1:0] gshare;
  } gc_word_t;

  typedef struct packed {
    logic             pred;
    logic [CTR_W-1:0] chooser;
    logic [CTR_W-1:0] gshare;
    logic [CTR_W-1:0] lctr;
  } eval_t;

endpackage

FILE: rtl/tbp_ram.sv
module tbp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tbp_eval.sv
module tbp_eval import tbp_pkg::*; (
  input  gc_word_t         gc,
  input  logic [CTR_W-1:0] lctr,
  input  logic             train,
  input  logic             taken,
  output eval_t            ev
);

  function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? c : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? c : c - 2'd1;
    end
    return r;
  endfunction

  logic gpred;
  logic lpred;
  logic gok;
  logic lok;

  always_comb begin
    gpred = gc.gshare[CTR_W-1];
    lpred = lctr[CTR_W-1];
    gok   = (gpred == taken);
    lok   = (lpred == taken);

    ev.pred = gc.chooser[CTR_W-1] ? gpred : lpred;

    // The chooser only moves when exactly one side was right.
    ev.chooser = gc.chooser;
    if (train && gok && !lok) begin
      ev.chooser = sat_move(gc.chooser, 1'b1);
    end else if (train && !gok && lok) begin
      ev.chooser = sat_move(gc.chooser, 1'b0);
    end

    ev.gshare = sat_move(gc.gshare, taken);
    ev.lctr   = sat_move(lctr, taken);
  end

endmodule

FILE: rtl/tournament_branch_predictor.sv
// Channel  Dir  Fields (tdata/tuser, lowest bit first)      Accepted when
// s_       in   tuser: kind; tdata: pc[31:0], outcome[32]   s_tvalid && s_tready
// m_       out  tdata: predict_taken[0]                      m_tvalid && m_tready
//
// Each item is handled in steps: the accept edge reads the local history and the
// gshare/chooser word, the next cycle reads the local counter at that history,
// and S_EVAL evaluates the prediction and writes back the updates on a train.
// The local counter read depends on the local history read.
// After reset a clearing pass writes every table entry, one entry per cycle, over
// 2^max(GHIST_BITS, PC_INDEX_BITS, LHIST_BITS) sweep addresses (8192 by default);
// s_tready stays low meanwhile. A stalled result holds the block in its last step.
module tournament_branch_predictor import tbp_pkg::*; #(
  parameter int GHIST_BITS    = 13,
  parameter int LHIST_BITS    = 3,
  parameter int PC_INDEX_BITS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pc[31:0], outcome[32], zero fill
  input  logic        s_tuser,   // kind: 0 predict, 1 train
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // predict_taken[0], zero fill
);

  // The gshare index is as wide as the wider of the global history and pc index.
  localparam int GS_BITS    = (GHIST_BITS > PC_INDEX_BITS) ? GHIST_BITS : PC_INDEX_BITS;
  localparam int SWEEP_BITS = (GS_BITS > LHIST_BITS) ? GS_BITS : LHIST_BITS;

  state_t state, state_next;

  logic [SWEEP_BITS-1:0]    sweep;
  logic [GHIST_BITS-1:0]    ghist;
  logic                     kind_q;
  logic                     taken_q;
  logic [PC_INDEX_BITS-1:0] pcx_q;
  logic [GS_BITS-1:0]       gi_q;
  logic [LHIST_BITS-1:0]    li_q;
  logic                     pred_q;

  logic                     accept;
  logic                     out_free;
  logic                     advance;
  logic                     upd;
  logic                     clearing;
  logic [PC_INDEX_BITS-1:0] pcx_in;
  logic [GS_BITS-1:0]       gi_in;

  gc_word_t                 gc_rdata;
  gc_word_t                 gc_wdata;
  logic [LHIST_BITS-1:0]    lh_rdata;
  logic [LHIST_BITS-1:0]    lh_wdata;
  logic [CTR_W-1:0]         lc_rdata;
  logic [CTR_W-1:0]         lc_wdata;
  logic [GS_BITS-1:0]       gc_waddr;
  logic [PC_INDEX_BITS-1:0] lh_waddr;
  logic [LHIST_BITS-1:0]    lc_waddr;
  eval_t                    ev;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign advance  = (state == S_EVAL) && out_free;
  assign upd      = advance && (kind_q == KIND_TRAIN);
  assign clearing = (state == S_CLEAR);

  assign pcx_in = s_tdata[PC_INDEX_BITS-1:0];
  assign gi_in  = GS_BITS'(pcx_in) ^ GS_BITS'(ghist);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sweep == '1) state_next = S_IDLE;
      S_IDLE:  if (s_tvalid) state_next = S_LH;
      S_LH:    state_next = S_EVAL;
      S_EVAL:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (clearing) begin
      sweep <= sweep + 1'b1;
    end
  end

  // Global history shifts in the outcome when a train request retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
    end else if (upd) begin
      ghist <= GHIST_BITS'({ghist, taken_q});
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= s_tuser;
      taken_q <= s_tdata[32];
      pcx_q   <= pcx_in;
      gi_q    <= gi_in;
    end
    if (state == S_LH) begin
      li_q <= lh_rdata;
    end
    if (advance) begin
      pred_q <= ev.pred;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, pred_q};

  // Write side: the clearing pass owns the ports until it finishes.
  always_comb begin
    if (clearing) begin
      gc_waddr = sweep[GS_BITS-1:0];
      lh_waddr = sweep[PC_INDEX_BITS-1:0];
      lc_waddr = sweep[LHIST_BITS-1:0];
      gc_wdata = '{chooser: CHOOSER_INIT, gshare: GSHARE_INIT};
      lh_wdata = '0;
      lc_wdata = LCTR_INIT;
    end else begin
      gc_waddr = gi_q;
      lh_waddr = pcx_q;
      lc_waddr = li_q;
      gc_wdata = '{chooser: ev.chooser, gshare: ev.gshare};
      lh_wdata = LHIST_BITS'({li_q, taken_q});
      lc_wdata = ev.lctr;
    end
  end

  tbp_ram #(
    .WIDTH ($bits(gc_word_t)),
    .DEPTH (2 ** GS_BITS)
  ) u_gc_ram (
    .clk   (clk),
    .we    (clearing || upd),
    .waddr (gc_waddr),
    .wdata (gc_wdata),
    .re    (accept),
    .raddr (gi_in),
    .rdata (gc_rdata)
  );

  tbp_ram #(
    .WIDTH (LHIST_BITS),
    .DEPTH (2 ** PC_INDEX_BITS)
  ) u_lh_ram (
    .clk   (clk),
    .we    (clearing || upd),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .re    (accept),
    .raddr (pcx_in),
    .rdata (lh_rdata)
  );

  tbp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (2 ** LHIST_BITS)
  ) u_lc_ram (
    .clk   (clk),
    .we    (clearing || upd),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (state == S_LH),
    .raddr (lh_rdata),
    .rdata (lc_rdata)
  );

  tbp_eval u_eval (
    .gc    (gc_rdata),
    .lctr  (lc_rdata),
    .train (kind_q == KIND_TRAIN),
    .taken (taken_q),
    .ev    (ev)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during clearing pass");

  a_accept_to_lh: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LH))
    else $error("accepted beat did not start the local history read");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EVAL))
    else $error("result raised outside evaluation step");

  a_ghist_only_train: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ghist != $past(ghist)) |->
      ($past(state) == S_EVAL && $past(kind_q) == KIND_TRAIN))
    else $error("global history changed without a retiring train");
`endif

endmodule
